>>> src/tiia_pkg.sv
`default_nettype none
package tiia_pkg;

	localparam int MAX_BLOCK = 5114;
	localparam int MAX_ROWS  = 20;
	localparam int MIN_BLOCK = 40;
	localparam int NUM_PRIMES = 52;

	localparam logic [12:0] K_MIN      = 13'(MIN_BLOCK);
	localparam logic [12:0] K_MAX      = 13'(MAX_BLOCK);
	localparam logic [12:0] K_P1_HIGH  = 13'd3211;
	localparam logic [12:0] K_P2_HIGH  = 13'd3161;
	localparam logic [12:0] K_P1_MID   = 13'd2481;
	localparam logic [12:0] K_P2_LOW   = 13'd2281;
	localparam logic [12:0] K_P3_HIGH  = 13'd530;
	localparam logic [12:0] K_P3_LOW   = 13'd481;
	localparam logic [12:0] K_R5_HIGH  = 13'd159;
	localparam logic [12:0] K_R10_HIGH = 13'd200;
	localparam logic [12:0] K_P0_LOW   = 13'd201;
	localparam logic [12:0] K_P2B_LOW  = 13'd160;

	localparam logic [1:0] PAT_A = 2'd0;
	localparam logic [1:0] PAT_B = 2'd1;
	localparam logic [1:0] PAT_C = 2'd2;
	localparam logic [1:0] PAT_D = 2'd3;

	localparam logic [5:0] LAST_PRIME_IDX = 6'(NUM_PRIMES - 1);
	localparam logic [5:0] END_PRIME_IDX  = 6'(NUM_PRIMES);

	localparam logic [8:0] PRIMES [NUM_PRIMES] = '{
		9'd7, 9'd11, 9'd13, 9'd17, 9'd19, 9'd23, 9'd29, 9'd31, 9'd37, 9'd41, 9'd43,
		9'd47, 9'd53, 9'd59, 9'd61, 9'd67, 9'd71, 9'd73, 9'd79, 9'd83, 9'd89, 9'd97,
		9'd101, 9'd103, 9'd107, 9'd109, 9'd113, 9'd127, 9'd131, 9'd137, 9'd139,
		9'd149, 9'd151, 9'd157, 9'd163, 9'd167, 9'd173, 9'd179, 9'd181, 9'd191,
		9'd193, 9'd197, 9'd199, 9'd211, 9'd223, 9'd227, 9'd229, 9'd233, 9'd239,
		9'd241, 9'd251, 9'd257
	};

	localparam logic [4:0] ROOTS [NUM_PRIMES] = '{
		5'd3, 5'd2, 5'd2, 5'd3, 5'd2, 5'd5, 5'd2, 5'd3, 5'd2, 5'd6, 5'd3, 5'd5,
		5'd2, 5'd2, 5'd2, 5'd2, 5'd7, 5'd5, 5'd3, 5'd2, 5'd3, 5'd5, 5'd2, 5'd5,
		5'd2, 5'd6, 5'd3, 5'd3, 5'd2, 5'd3, 5'd2, 5'd2, 5'd6, 5'd5, 5'd2, 5'd5,
		5'd2, 5'd2, 5'd2, 5'd19, 5'd5, 5'd2, 5'd3, 5'd2, 5'd3, 5'd2, 5'd6, 5'd3,
		5'd7, 5'd7, 5'd6, 5'd3
	};

	localparam logic [4:0] ROWS_A [MAX_ROWS] = '{
		5'd19, 5'd9, 5'd14, 5'd4, 5'd0, 5'd2, 5'd5, 5'd7, 5'd12, 5'd18,
		5'd10, 5'd8, 5'd13, 5'd17, 5'd3, 5'd1, 5'd16, 5'd6, 5'd15, 5'd11
	};
	localparam logic [4:0] ROWS_B [MAX_ROWS] = '{
		5'd19, 5'd9, 5'd14, 5'd4, 5'd0, 5'd2, 5'd5, 5'd7, 5'd12, 5'd18,
		5'd16, 5'd13, 5'd17, 5'd15, 5'd3, 5'd1, 5'd6, 5'd11, 5'd8, 5'd10
	};
	localparam logic [4:0] ROWS_C [MAX_ROWS] = '{
		5'd9, 5'd8, 5'd7, 5'd6, 5'd5, 5'd4, 5'd3, 5'd2, 5'd1, 5'd0,
		5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0
	};
	localparam logic [4:0] ROWS_D [MAX_ROWS] = '{
		5'd4, 5'd3, 5'd2, 5'd1, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
		5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0
	};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_PSRCH,
		ST_COL,
		ST_SWAP,
		ST_SEQ0,
		ST_SEQ,
		ST_QRED,
		ST_QCHK,
		ST_WALK_A,
		ST_WALK_B
	} state_t;

	function automatic logic [8:0] prime_at(input logic [5:0] idx);
		logic [8:0] res;
		res = (idx < END_PRIME_IDX) ? PRIMES[idx] : 9'd0;
		return res;
	endfunction

	function automatic logic [4:0] root_at(input logic [5:0] idx);
		logic [4:0] res;
		res = (idx < END_PRIME_IDX) ? ROOTS[idx] : 5'd0;
		return res;
	endfunction

	function automatic logic [4:0] row_at(input logic [1:0] sel, input logic [4:0] idx);
		logic [4:0] res;
		res = 5'd0;
		if (idx < 5'(MAX_ROWS)) begin
			unique case (sel)
				PAT_A: res = ROWS_A[idx];
				PAT_B: res = ROWS_B[idx];
				PAT_C: res = ROWS_C[idx];
				PAT_D: res = ROWS_D[idx];
				default: res = 5'd0;
			endcase
		end
		return res;
	endfunction

	function automatic logic [1:0] pattern_for(input logic [12:0] k);
		logic [1:0] res;
		if (k >= K_P1_HIGH) res = PAT_A;
		else if (k >= K_P2_HIGH) res = PAT_B;
		else if (k >= K_P1_MID) res = PAT_A;
		else if (k >= K_P2_LOW) res = PAT_B;
		else if (k > K_P3_HIGH) res = PAT_A;
		else if (k >= K_P3_LOW) res = PAT_C;
		else if (k >= K_P0_LOW) res = PAT_A;
		else if (k >= K_P2B_LOW) res = PAT_C;
		else res = PAT_D;
		return res;
	endfunction

endpackage
`default_nettype wire

>>> src/tiia_ram.sv
`default_nettype none
module tiia_ram #(
	parameter int AW = 8,
	parameter int DW = 9
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

>>> src/turbo_internal_interleaver_address.sv
// Turbo-code internal interleaver address generator.
// Channels: cfg_valid/cfg_ready/cfg_data writes block size K (always ready;
// write only while idle, used at the next restart). s_* carries one request
// per item: s_tdata[0] = restart. m_* returns one item per request:
// m_tdata[12:0] = address, m_tlast = last address of the block.
// A restart (or the first request after reset) rebuilds the tables:
// prime search, base sequence (one entry at a time through the shift-add
// modular multiplier), then the row prime search with repeated-subtraction
// divisibility checks, all before the first address of the block is found.
// Other requests examine one candidate at a time (base sequence RAM
// read, then compare against K); each pruned candidate adds another read and compare.
// s_tready is high only while no request is in work. When the receiver stalls,
// the finished address waits in the walk stage and the output register holds.
// Reset clears the state, the row and column counts, the walk position and the output
// valid; K resets to 40 and the first request builds the tables.
`default_nettype none
module turbo_internal_interleaver_address (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [12:0] cfg_data,     // block_size
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,      // [0] restart, [7:1] zero
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [15:0] m_tdata,      // [12:0] address, [15:13] zero
	output logic             m_tlast       // last
);

	tiia_pkg::state_t state_q, state_d;

	logic [12:0] block_size_q;
	logic [12:0] k_q;
	logic [4:0]  rr_q;
	logic [1:0]  psel_q;
	logic [8:0]  p_q;
	logic [4:0]  v_q;
	logic [8:0]  c_q;
	logic        swap_q;
	logic [5:0]  pi_q;
	logic [8:0]  i_q;
	logic [8:0]  sprev_q;
	logic [8:0]  macc_q;
	logic [2:0]  bit_q;
	logic [4:0]  j_q;
	logic [8:0]  rem_q;
	logic [8:0]  rq_q;
	logic [7:0]  rp_q  [tiia_pkg::MAX_ROWS];
	logic [7:0]  acc_q [tiia_pkg::MAX_ROWS];
	logic [4:0]  row_pos_q;
	logic [8:0]  col_pos_q;
	logic [12:0] emitted_q;
	logic [4:0]  row_s1;
	logic [8:0]  col_s1;
	logic [12:0] addr_q;
	logic        last_q;
	logic        mvalid_q;

	logic        s_acc;
	logic        build_req;
	logic        wstep;
	logic        zero_pos;
	logic [4:0]  rpos;
	logic [8:0]  cpos;
	logic [4:0]  row_a;
	logic [7:0]  acc_a;
	logic [8:0]  acc_sum;
	logic [7:0]  acc_nxt;
	logic        row_wrap;
	logic        col_wrap;
	logic [8:0]  pm1;
	logic [12:0] kc;
	logic [4:0]  rr_init;
	logic        spec53;
	logic [14:0] prod_ps;
	logic        ps_hit;
	logic [13:0] prod_cm1;
	logic [13:0] prod_cp;
	logic [13:0] prod_rc;
	logic [9:0]  t1, t1r, t2, t2r;
	logic [9:0]  i_next_p1;
	logic        seq_more;
	logic [8:0]  cand;
	logic        q_last;
	logic [8:0]  sv;
	logic [8:0]  u;
	logic [13:0] idx;
	logic        found;
	logic        ofree;
	logic        emit;
	logic [12:0] emitted_inc;
	logic        ram_we;
	logic [7:0]  ram_waddr;
	logic [8:0]  ram_wdata;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == tiia_pkg::ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign build_req = s_tdata[0] || (rr_q == 5'd0) || (c_q == 9'd0);
	assign m_tvalid  = mvalid_q;
	assign m_tdata   = {3'd0, addr_q};
	assign m_tlast   = last_q;

	assign pm1 = p_q - 9'd1;

	// build arithmetic
	always_comb begin
		if (block_size_q < tiia_pkg::K_MIN) kc = tiia_pkg::K_MIN;
		else if (block_size_q > tiia_pkg::K_MAX) kc = tiia_pkg::K_MAX;
		else kc = block_size_q;
		spec53 = (kc >= tiia_pkg::K_P3_LOW) && (kc <= tiia_pkg::K_P3_HIGH);
		if (kc <= tiia_pkg::K_R5_HIGH) rr_init = 5'd5;
		else if (kc <= tiia_pkg::K_R10_HIGH) rr_init = 5'd10;
		else if (spec53) rr_init = 5'd10;
		else rr_init = 5'd20;
	end

	assign prod_ps  = 15'(rr_q) * 15'({1'b0, tiia_pkg::prime_at(pi_q)} + 10'd1);
	assign ps_hit   = (prod_ps >= 15'(k_q)) || (pi_q == tiia_pkg::LAST_PRIME_IDX);
	assign prod_cm1 = 14'(rr_q) * 14'(pm1);
	assign prod_cp  = 14'(rr_q) * 14'(p_q);
	assign prod_rc  = 14'(rr_q) * 14'(c_q);

	// shift-add modular multiply step: macc = 2*macc + bit*sprev mod p
	always_comb begin
		t1  = {macc_q, 1'b0};
		t1r = (t1 >= 10'(p_q)) ? t1 - 10'(p_q) : t1;
		t2  = t1r + (v_q[bit_q] ? 10'(sprev_q) : 10'd0);
		t2r = (t2 >= 10'(p_q)) ? t2 - 10'(p_q) : t2;
	end

	assign i_next_p1 = 10'(i_q) + 10'd2;
	assign seq_more  = (i_next_p1 < 10'(p_q)) && (i_q < 9'd255);

	assign cand   = tiia_pkg::prime_at(pi_q);
	assign q_last = (j_q + 5'd1 == rr_q);

	// walk step
	assign wstep    = (state_q == tiia_pkg::ST_WALK_A) || (s_acc && !build_req);
	assign zero_pos = (state_q == tiia_pkg::ST_IDLE) && (emitted_q >= k_q);
	assign rpos     = zero_pos ? 5'd0 : row_pos_q;
	assign cpos     = zero_pos ? 9'd0 : col_pos_q;
	assign row_a    = tiia_pkg::row_at(psel_q, rpos);
	assign acc_a    = zero_pos ? 8'd0 : acc_q[row_a];
	assign acc_sum  = 9'(acc_a) + 9'(rp_q[row_a]);
	assign acc_nxt  = (acc_sum >= pm1) ? 8'(acc_sum - pm1) : acc_sum[7:0];
	assign row_wrap = (rpos + 5'd1 >= rr_q);
	assign col_wrap = row_wrap && (cpos + 9'd1 >= c_q);

	// column value
	always_comb begin
		if (swap_q && (row_s1 + 5'd1 == rr_q) && (col_s1 == 9'd0)) u = p_q;
		else if (swap_q && (row_s1 + 5'd1 == rr_q) && (col_s1 == p_q)) u = 9'd1;
		else if ((c_q != pm1) && (col_s1 == pm1)) u = 9'd0;
		else if ((c_q == p_q + 9'd1) && (col_s1 == p_q)) u = p_q;
		else if (c_q == pm1) u = sv - 9'd1;
		else u = sv;
	end

	assign idx         = 14'(row_s1) * 14'(c_q) + 14'(u);
	assign found       = (idx < 14'(k_q));
	assign ofree       = !mvalid_q || m_tready;
	assign emit        = (state_q == tiia_pkg::ST_WALK_B) && found && ofree;
	assign emitted_inc = emitted_q + 13'd1;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = 8'd0;
		ram_wdata = 9'd1;
		if (state_q == tiia_pkg::ST_SEQ0) begin
			ram_we = 1'b1;
		end else if ((state_q == tiia_pkg::ST_SEQ) && (bit_q == 3'd0)) begin
			ram_we    = 1'b1;
			ram_waddr = i_q[7:0];
			ram_wdata = t2r[8:0];
		end
	end

	tiia_ram #(
		.AW(8),
		.DW(9)
	) u_seq_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (wstep),
		.raddr (acc_a),
		.rdata (sv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tiia_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tiia_pkg::ST_IDLE: begin
				if (s_acc) state_d = build_req ? tiia_pkg::ST_INIT : tiia_pkg::ST_WALK_B;
			end
			tiia_pkg::ST_INIT: state_d = spec53 ? tiia_pkg::ST_SWAP : tiia_pkg::ST_PSRCH;
			tiia_pkg::ST_PSRCH: if (ps_hit) state_d = tiia_pkg::ST_COL;
			tiia_pkg::ST_COL: state_d = tiia_pkg::ST_SWAP;
			tiia_pkg::ST_SWAP: state_d = tiia_pkg::ST_SEQ0;
			tiia_pkg::ST_SEQ0: state_d = tiia_pkg::ST_SEQ;
			tiia_pkg::ST_SEQ: begin
				if ((bit_q == 3'd0) && !seq_more) state_d = tiia_pkg::ST_QRED;
			end
			tiia_pkg::ST_QRED: begin
				if (rq_q < pm1) state_d = q_last ? tiia_pkg::ST_WALK_A : tiia_pkg::ST_QCHK;
			end
			tiia_pkg::ST_QCHK: begin
				if (pi_q == tiia_pkg::END_PRIME_IDX) state_d = tiia_pkg::ST_QRED;
				else if ((rem_q < cand) && (rem_q != 9'd0)) state_d = tiia_pkg::ST_QRED;
			end
			tiia_pkg::ST_WALK_A: state_d = tiia_pkg::ST_WALK_B;
			tiia_pkg::ST_WALK_B: begin
				if (!found) state_d = tiia_pkg::ST_WALK_A;
				else if (ofree) state_d = tiia_pkg::ST_IDLE;
			end
			default: state_d = tiia_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q <= tiia_pkg::K_MIN;
			k_q          <= 13'd0;
			rr_q         <= 5'd0;
			c_q          <= 9'd0;
			row_pos_q    <= 5'd0;
			col_pos_q    <= 9'd0;
			emitted_q    <= 13'd0;
			mvalid_q     <= 1'b0;
		end else begin
			if (cfg_valid) begin
				block_size_q <= cfg_data;
			end
			if (emit) begin
				mvalid_q <= 1'b1;
			end else if (m_tready) begin
				mvalid_q <= 1'b0;
			end
			if (emit) begin
				emitted_q <= emitted_inc;
			end else if (wstep && zero_pos) begin
				emitted_q <= 13'd0;
			end
			if (state_q == tiia_pkg::ST_INIT) begin
				k_q  <= kc;
				rr_q <= rr_init;
				if (spec53) c_q <= 9'd53;
			end
			if (state_q == tiia_pkg::ST_COL) begin
				if (prod_cm1 >= 14'(k_q)) c_q <= pm1;
				else if (prod_cp >= 14'(k_q)) c_q <= p_q;
				else c_q <= p_q + 9'd1;
			end
			if ((state_q == tiia_pkg::ST_QRED) && (rq_q < pm1) && q_last) begin
				row_pos_q <= 5'd0;
				col_pos_q <= 9'd0;
				emitted_q <= 13'd0;
			end
			if (wstep) begin
				if (row_wrap) begin
					row_pos_q <= 5'd0;
					col_pos_q <= col_wrap ? 9'd0 : cpos + 9'd1;
				end else begin
					row_pos_q <= rpos + 5'd1;
					col_pos_q <= cpos;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tiia_pkg::ST_INIT) begin
			psel_q <= tiia_pkg::pattern_for(kc);
			pi_q   <= 6'd0;
			if (spec53) begin
				p_q <= 9'd53;
				v_q <= 5'd2;
			end
		end
		if ((state_q == tiia_pkg::ST_PSRCH) && ps_hit) begin
			p_q  <= tiia_pkg::prime_at(pi_q);
			v_q  <= tiia_pkg::root_at(pi_q);
		end else if (state_q == tiia_pkg::ST_PSRCH) begin
			pi_q <= pi_q + 6'd1;
		end
		if (state_q == tiia_pkg::ST_SWAP) begin
			swap_q <= (c_q == p_q + 9'd1) && (prod_rc == 14'(k_q));
			pi_q   <= 6'd0;
		end
		if (state_q == tiia_pkg::ST_SEQ0) begin
			i_q     <= 9'd1;
			sprev_q <= 9'd1;
			macc_q  <= 9'd0;
			bit_q   <= 3'd4;
		end
		if (state_q == tiia_pkg::ST_SEQ) begin
			if (bit_q == 3'd0) begin
				sprev_q <= t2r[8:0];
				i_q     <= i_q + 9'd1;
				macc_q  <= 9'd0;
				bit_q   <= 3'd4;
				if (!seq_more) begin
					j_q  <= 5'd0;
					rq_q <= 9'd1;
				end
			end else begin
				macc_q <= t2r[8:0];
				bit_q  <= bit_q - 3'd1;
			end
		end
		if (state_q == tiia_pkg::ST_QRED) begin
			if (rq_q >= pm1) begin
				rq_q <= rq_q - pm1;
			end else begin
				rp_q[tiia_pkg::row_at(psel_q, j_q)] <= rq_q[7:0];
				j_q   <= j_q + 5'd1;
				rem_q <= pm1;
			end
		end
		if (state_q == tiia_pkg::ST_QCHK) begin
			if (pi_q == tiia_pkg::END_PRIME_IDX) begin
				rq_q <= 9'd0;
			end else if (rem_q >= cand) begin
				rem_q <= rem_q - cand;
			end else if (rem_q != 9'd0) begin
				rq_q <= cand;
				pi_q <= pi_q + 6'd1;
			end else begin
				pi_q  <= pi_q + 6'd1;
				rem_q <= pm1;
			end
		end
		if ((state_q == tiia_pkg::ST_QRED) && (rq_q < pm1) && q_last) begin
			for (int n = 0; n < tiia_pkg::MAX_ROWS; n++) begin
				acc_q[n] <= 8'd0;
			end
		end
		if (wstep) begin
			row_s1 <= row_a;
			col_s1 <= cpos;
			for (int n = 0; n < tiia_pkg::MAX_ROWS; n++) begin
				if (!col_wrap && (5'(n) == row_a)) begin
					acc_q[n] <= acc_nxt;
				end else if (col_wrap || zero_pos) begin
					acc_q[n] <= 8'd0;
				end
			end
		end
		if (emit) begin
			addr_q <= idx[12:0];
			last_q <= (emitted_inc == k_q);
		end
	end

	a_addr_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (m_tdata[12:0] < k_q))
		else $error("address not below block size");

	a_last_count: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (m_tlast == (emitted_q == k_q)))
		else $error("last flag does not match count");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> m_tvalid)
		else $error("found address not presented");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tiia_pkg::ST_WALK_A) |-> (row_pos_q < rr_q))
		else $error("row position out of range");

endmodule
`default_nettype wire

>>> tb/tb_turbo_internal_interleaver_address.sv
`default_nettype none
module tb_turbo_internal_interleaver_address;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [12:0] addr;
		logic        last;
	} addr_item_t;

	class interleaver_scoreboard;
		int blk_size, prime, root, rows, cols, col_pos, row_pos, emitted, active_k;
		int seq[256];
		int rprime[20];
		addr_item_t pending[$];
		int errors, requests, addresses, restarts;

		function new();
			blk_size = tiia_pkg::MIN_BLOCK;
			foreach (seq[i]) seq[i] = 0;
			foreach (rprime[i]) rprime[i] = 0;
		endfunction

		function void set_size(int v);
			blk_size = v & 'h1fff;
		endfunction

		function int pat_sel(int k);
			if (k >= 3211) return tiia_pkg::PAT_A;
			if (k >= 3161) return tiia_pkg::PAT_B;
			if (k >= 2481) return tiia_pkg::PAT_A;
			if (k >= 2281) return tiia_pkg::PAT_B;
			if (k > 530) return tiia_pkg::PAT_A;
			if (k >= 481) return tiia_pkg::PAT_C;
			if (k >= 201) return tiia_pkg::PAT_A;
			if (k >= 160) return tiia_pkg::PAT_C;
			return tiia_pkg::PAT_D;
		endfunction

		function int pat_row(int sel, int i);
			if (i >= 20) return 0;
			case (sel)
				tiia_pkg::PAT_A: return tiia_pkg::ROWS_A[i];
				tiia_pkg::PAT_B: return tiia_pkg::ROWS_B[i];
				tiia_pkg::PAT_C: return tiia_pkg::ROWS_C[i];
				default: return tiia_pkg::ROWS_D[i];
			endcase
		endfunction

		function int gcd(int a, int b);
			int t;
			while (b != 0) begin
				t = a % b;
				a = b;
				b = t;
			end
			return a;
		endfunction

		function void rebuild();
			int k, p, v, c, sel;
			int q[20];
			k = blk_size;
			p = tiia_pkg::PRIMES[tiia_pkg::NUM_PRIMES-1];
			v = tiia_pkg::ROOTS[tiia_pkg::NUM_PRIMES-1];
			restarts++;
			if (k < tiia_pkg::MIN_BLOCK) k = tiia_pkg::MIN_BLOCK;
			if (k > tiia_pkg::MAX_BLOCK) k = tiia_pkg::MAX_BLOCK;
			active_k = k;
			if (k <= 159) rows = 5;
			else if (k <= 200) rows = 10;
			else if (k >= 481 && k <= 530) rows = 10;
			else rows = 20;
			if (k >= 481 && k <= 530) begin
				p = 53; v = 2; c = 53;
			end else begin
				for (int i = 0; i < tiia_pkg::NUM_PRIMES; i++) begin
					if (rows * (tiia_pkg::PRIMES[i] + 1) >= k) begin
						p = tiia_pkg::PRIMES[i]; v = tiia_pkg::ROOTS[i];
						break;
					end
				end
				if (rows * (p - 1) >= k) c = p - 1;
				else if (rows * p >= k) c = p;
				else c = p + 1;
			end
			prime = p; root = v; cols = c;
			seq[0] = 1;
			for (int i = 1; i + 1 < p && i < 256; i++)
				seq[i] = (v * seq[i-1]) % p;
			q[0] = 1;
			for (int j = 1; j < rows; j++) begin
				q[j] = 0;
				for (int i = 0; i < tiia_pkg::NUM_PRIMES; i++) begin
					if (tiia_pkg::PRIMES[i] > 6 && tiia_pkg::PRIMES[i] > q[j-1] &&
						gcd(tiia_pkg::PRIMES[i], p - 1) == 1) begin
						q[j] = tiia_pkg::PRIMES[i];
						break;
					end
				end
			end
			sel = pat_sel(k);
			for (int j = 0; j < rows; j++) rprime[pat_row(sel, j)] = q[j];
			col_pos = 0; row_pos = 0; emitted = 0;
		endfunction

		function int col_value(int row, int col);
			int r, sv;
			r = (row < 20) ? rprime[row] : 0;
			if (prime < 2) return 0;
			if (cols == prime + 1 && active_k == rows * cols && row + 1 == rows) begin
				if (col == 0) return prime;
				if (col == prime) return 1;
			end
			if (cols != prime - 1 && col == prime - 1) return 0;
			if (cols == prime + 1 && col == prime) return prime;
			sv = seq[((col * r) % (prime - 1)) & 'hff];
			if (cols == prime - 1) return (sv - 1) & 'h1ff;
			return sv;
		endfunction

		function void note_request(bit restart);
			addr_item_t e;
			int sel, row, idx;
			bit found;
			requests++;
			if (restart || rows == 0 || cols == 0) rebuild();
			else if (emitted >= active_k) begin
				col_pos = 0; row_pos = 0; emitted = 0;
			end
			sel = pat_sel(active_k);
			e.addr = 0;
			e.last = 0;
			found = 0;
			for (int g = rows * cols; g > 0; g--) begin
				row = pat_row(sel, row_pos);
				idx = row * cols + col_value(row, col_pos);
				row_pos++;
				if (row_pos >= rows) begin
					row_pos = 0;
					col_pos++;
					if (col_pos >= cols) col_pos = 0;
				end
				if (idx < active_k) begin
					e.addr = idx;
					found = 1;
					break;
				end
			end
			if (found) begin
				emitted = (emitted + 1) & 'h1fff;
				e.last = (emitted == active_k);
			end
			pending.push_back(e);
		endfunction

		function void check_address(logic [12:0] addr, logic last);
			addr_item_t e;
			addresses++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected address %0d last %0b", $time, addr, last);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (addr !== e.addr) begin
				$display("%0t: address expected %0d actual %0d", $time, e.addr, addr);
				errors++;
			end
			if (last !== e.last) begin
				$display("%0t: last expected %0b actual %0b", $time, e.last, last);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [12:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;      // [0] restart
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;      // [12:0] address
	logic        m_tlast;      // last

	interleaver_scoreboard sb;
	int  burst_left;
	bit  hold_go;
	bit  hold_done;
	longint cycles;

	turbo_internal_interleaver_address uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_turbo_internal_interleaver_address failed");
			$finish;
		end
	end

	// values are stable from the falling edge up to the next rising edge
	always @(negedge clk)
		if (arst_n && m_tvalid && m_tready) sb.check_address(m_tdata[12:0], m_tlast);

	initial begin
		int pct;
		wait (arst_n === 1'b1);
		forever begin
			pct = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(10, 70);
			repeat ($urandom_range(20, 80)) begin
				@(posedge clk);
				if (hold_go && !hold_done) begin
					m_tready <= 1'b0;
					repeat (400) @(posedge clk);
					hold_done = 1;
				end
				m_tready <= ($urandom_range(0, 99) >= pct);
			end
		end
	end

	task automatic write_size(int k);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= 13'(k);
		forever begin
			@(negedge clk);
			if (cfg_ready) break;
		end
		@(posedge clk);
		cfg_valid <= 1'b0;
		sb.set_size(k);
	endtask

	task automatic send_request(bit restart);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			if ($urandom_range(0, 3) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, restart};
		forever begin
			@(negedge clk);
			if (s_tready) break;
		end
		@(posedge clk);
		sb.note_request(restart);
	endtask

	task automatic drain();
		@(posedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int dir_sizes[13] = '{0, 8191, 159, 160, 200, 201, 481, 530, 531, 2281, 2481, 3161, 3211};
		int picks[7] = '{0, 40, 60, 8191, 5114, 159, 160};
		int k, n, phases;
		sb = new();
		clk = 0; arst_n = 0;
		cfg_valid = 0; cfg_data = '0;
		s_tvalid = 0; s_tdata = '0;
		m_tready = 0;
		burst_left = 0; hold_go = 0; hold_done = 0; cycles = 0; phases = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// first request after reset builds the tables by itself
		repeat (3) send_request(0);
		drain();
		foreach (dir_sizes[i]) begin
			write_size(dir_sizes[i]);
			send_request(1);
			send_request(0);
			drain();
		end

		while (sb.requests < 1050) begin
			phases++;
			case ($urandom_range(0, 19))
				0, 1, 2: k = picks[$urandom_range(0, 6)];
				3, 4: k = $urandom_range(601, 8191);
				default: k = $urandom_range(0, 600);
			endcase
			write_size(k);
			// long receiver hold-off while this phase keeps offering requests
			if (!hold_go && sb.requests >= 400) hold_go = 1;
			// sometimes keep walking the old block; the new size waits for a restart
			send_request($urandom_range(0, 4) != 0);
			n = (sb.active_k <= 250) ? sb.active_k + $urandom_range(0, 8)
				: $urandom_range(20, 60);
			repeat (n) send_request($urandom_range(0, 99) < 3);
			drain();
		end
		repeat (50) @(posedge clk);

		$display("%0d requests, %0d addresses, %0d table builds, %0d random block sizes",
			sb.requests, sb.addresses, sb.restarts, phases);
		$display("receiver long hold-off done: %0b", hold_done);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("tb_turbo_internal_interleaver_address passed");
		end else begin
			$display("%0d errors, %0d addresses missing", sb.errors, sb.pending.size());
			$display("tb_turbo_internal_interleaver_address failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
